/* design/csl_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// csl_pkg
// Shared widths, constants and register indexes of the cascaded servo loop.
// ----------------------------------------------------------------------------
package csl_pkg;

	localparam int PRODUCT_SHIFT = 8;
	localparam int POS_W         = 24;
	localparam int CMD_W         = 16;
	localparam int LIM_W         = 15;
	localparam int PWM_W         = 8;
	localparam int CFG_IDX_W     = 3;
	localparam int CFG_DATA_W    = 16;

	localparam logic [15:0] OVERLOAD_LIMIT_RST = 16'd1000;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MODE           = 3'd0,
		REG_SPEED_LIMIT    = 3'd1,
		REG_TORQUE_LIMIT   = 3'd2,
		REG_SPEED_GAIN     = 3'd3,
		REG_PROP_GAIN      = 3'd4,
		REG_INTEG_GAIN     = 3'd5,
		REG_EMF_GAIN       = 3'd6,
		REG_OVERLOAD_LIMIT = 3'd7
	} cfg_reg_t;

	typedef enum logic [1:0] {
		MODE_VOLTAGE  = 2'd0,
		MODE_TORQUE   = 2'd1,
		MODE_VELOCITY = 2'd2,
		MODE_POSITION = 2'd3
	} mode_t;

endpackage
`default_nettype wire

/* design/cascaded_servo_loop.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cascaded_servo_loop
// Position / velocity / torque servo with one shared bit-serial multiplier.
//
// One input word is a control tick: position, target_position and
// direct_command. Each tick yields one output word with complementary pwm
// duties, the torque clamp flags and the fault flag. Registers are written
// on the cfg channel (cfg_index, cfg_data); the user must write them only
// while the block is idle, which the block does not enforce; cfg_ready
// is always high. On the way to out_valid a tick uses no multiply in
// voltage mode or with the fault latched, the emf multiply in torque mode,
// and the speed, proportional, integral and emf multiplies in velocity and
// position modes (a tick that trips the fault skips the emf one). Each
// multiply runs in a radix-2 shift-and-add unit, one multiplier bit per cycle.
// A new tick is accepted in the cycle after the previous result is loaded into
// the output register, even while that result waits for out_ready; a held
// result stalls the sequencer only when the next result is ready to load.
// Reset clears the loop state, the fault latch and the registers
// (overload_limit resets to 1000).
// ----------------------------------------------------------------------------
module cascaded_servo_loop (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               in_valid,
	output logic                              in_ready,
	input  wire logic signed [csl_pkg::POS_W-1:0] position,
	input  wire logic signed [csl_pkg::POS_W-1:0] target_position,
	input  wire logic signed [csl_pkg::CMD_W-1:0] direct_command,
	output logic                              out_valid,
	input  wire                               out_ready,
	output logic [csl_pkg::PWM_W-1:0]         pwm_a,
	output logic [csl_pkg::PWM_W-1:0]         pwm_b,
	output logic                              clamp_low,
	output logic                              clamp_high,
	output logic                              fault,
	input  wire                               cfg_valid,
	output logic                              cfg_ready,
	input  wire [csl_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire [csl_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import csl_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE, S_VEL, S_MUL, S_ERR, S_Z1, S_Z, S_EMF, S_DRV
	} state_t;

	function automatic logic signed [15:0] sat16(input logic signed [31:0] x);
		if (x > 32'sd32767) begin
			return 16'sh7FFF;
		end else if (x < -32'sd32768) begin
			return 16'sh8000;
		end else begin
			return x[15:0];
		end
	endfunction

	// configuration registers
	logic [1:0]         mode_q;
	logic [LIM_W-1:0]   speed_limit_q;
	logic [LIM_W-1:0]   torque_limit_q;
	logic signed [15:0] speed_gain_q;
	logic signed [15:0] prop_gain_q;
	logic signed [15:0] integ_gain_q;
	logic signed [15:0] emf_gain_q;
	logic [15:0]        overload_limit_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q           <= '0;
			speed_limit_q    <= '0;
			torque_limit_q   <= '0;
			speed_gain_q     <= '0;
			prop_gain_q      <= '0;
			integ_gain_q     <= '0;
			emf_gain_q       <= '0;
			overload_limit_q <= OVERLOAD_LIMIT_RST;
		end else if (cfg_valid) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_MODE:           mode_q           <= cfg_data[1:0];
				REG_SPEED_LIMIT:    speed_limit_q    <= cfg_data[LIM_W-1:0];
				REG_TORQUE_LIMIT:   torque_limit_q   <= cfg_data[LIM_W-1:0];
				REG_SPEED_GAIN:     speed_gain_q     <= cfg_data;
				REG_PROP_GAIN:      prop_gain_q      <= cfg_data;
				REG_INTEG_GAIN:     integ_gain_q     <= cfg_data;
				REG_EMF_GAIN:       emf_gain_q       <= cfg_data;
				REG_OVERLOAD_LIMIT: overload_limit_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// datapath and sequencer registers
	state_t             state_q, ret_q;
	logic signed [POS_W-1:0] pos_q, tgt_q, prev_q;
	logic signed [15:0] cmd_q, vel_q, t_q, err_q, p2_q, integ_q;
	logic [15:0]        timer_q;
	logic               fault_q, neutral_q, trip_q, lo_q, hi_q;
	logic signed [15:0] mul_a_q;
	logic signed [16:0] acc_hi_q;
	logic [15:0]        acc_lo_q;
	logic [3:0]         cnt_q;
	logic               out_valid_q;
	logic [PWM_W-1:0]   pwm_a_q, pwm_b_q;
	logic               clamp_low_q, clamp_high_q, fault_out_q;
	logic               load_out;

	assign in_ready   = (state_q == S_IDLE);
	assign load_out   = (state_q == S_DRV) && (!out_valid_q || out_ready);
	assign out_valid  = out_valid_q;
	assign pwm_a      = pwm_a_q;
	assign pwm_b      = pwm_b_q;
	assign clamp_low  = clamp_low_q;
	assign clamp_high = clamp_high_q;
	assign fault      = fault_out_q;

	// serial multiplier step, last bit carries negative weight
	logic signed [17:0] a_ext, addend, step_sum;
	logic signed [31:0] prod_full;
	logic signed [15:0] mq;

	always_comb begin
		a_ext     = {{2{mul_a_q[15]}}, mul_a_q};
		addend    = '0;
		if (acc_lo_q[0]) begin
			addend = (cnt_q == 4'd15) ? -a_ext : a_ext;
		end
		step_sum  = {acc_hi_q[16], acc_hi_q} + addend;
		prod_full = {acc_hi_q[15:0], acc_lo_q};
		mq        = sat16(prod_full >>> PRODUCT_SHIFT);
	end

	// velocity and position error
	logic signed [POS_W:0] vel_diff, pos_err;
	logic signed [POS_W:0] slim_p, slim_n;
	logic signed [15:0]    vel_n, t_n;

	always_comb begin
		vel_diff = {pos_q[POS_W-1], pos_q} - {prev_q[POS_W-1], prev_q};
		if (vel_diff > 25'sd32767) begin
			vel_n = 16'sh7FFF;
		end else if (vel_diff < -25'sd32768) begin
			vel_n = 16'sh8000;
		end else begin
			vel_n = vel_diff[15:0];
		end
		pos_err = {tgt_q[POS_W-1], tgt_q} - {pos_q[POS_W-1], pos_q};
		slim_p  = $signed({{(POS_W+1-LIM_W){1'b0}}, speed_limit_q});
		slim_n  = -slim_p;
		priority if (mode_q != MODE_POSITION) begin
			t_n = cmd_q;
		end else if (pos_err >= slim_p) begin
			t_n = slim_p[15:0];
		end else if (pos_err <= slim_n) begin
			t_n = slim_n[15:0];
		end else begin
			t_n = pos_err[15:0];
		end
	end

	// torque clamp, anti-windup and overload timer
	logic signed [15:0] tlim_p, tlim_n, z_sat, z_n, integ_n, err_n;
	logic               lo_n, hi_n, check_n, trip_n;
	logic [16:0]        timer_up;
	logic [15:0]        timer_n;

	always_comb begin
		err_n   = sat16(32'(t_q) - 32'(mq));
		tlim_p  = $signed({1'b0, torque_limit_q});
		tlim_n  = -tlim_p;
		z_sat   = sat16(32'(p2_q) + 32'(mq));
		z_n     = z_sat;
		hi_n    = (z_sat >= tlim_p);
		if (hi_n) begin
			z_n = tlim_p;
		end
		lo_n    = (z_n <= tlim_n);
		if (lo_n) begin
			z_n = tlim_n;
		end
		integ_n = integ_q;
		if ((err_q[15] && !lo_n) || (!err_q[15] && !hi_n)) begin
			integ_n = sat16(32'(integ_q) + 32'(err_q));
		end
		timer_up = {1'b0, timer_q} + 17'd3;
		check_n  = 1'b1;
		priority if (lo_n || hi_n) begin
			timer_n = timer_up[16] ? 16'hFFFF : timer_up[15:0];
		end else if (timer_q == '0) begin
			timer_n = timer_q;
			check_n = 1'b0;
		end else begin
			timer_n = timer_q - 16'd1;
		end
		trip_n = check_n && (timer_n >= overload_limit_q);
	end

	// drive clip and halving
	logic signed [15:0] t_emf;
	logic signed [15:0] half;
	logic signed [7:0]  v_n;

	always_comb begin
		t_emf = sat16(32'(t_q) + 32'(mq));
		half  = (t_q + {15'd0, t_q[15]}) >>> 1;
		priority if (neutral_q) begin
			v_n = '0;
		end else if (t_q >= 16'sd240) begin
			v_n = 8'sd120;
		end else if (t_q < -16'sd240) begin
			v_n = -8'sd120;
		end else begin
			v_n = half[7:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			ret_q        <= S_IDLE;
			prev_q       <= '0;
			integ_q      <= '0;
			timer_q      <= '0;
			fault_q      <= 1'b0;
			neutral_q    <= 1'b0;
			trip_q       <= 1'b0;
			lo_q         <= 1'b0;
			hi_q         <= 1'b0;
			cnt_q        <= '0;
			out_valid_q  <= 1'b0;
			pwm_a_q      <= '0;
			pwm_b_q      <= '0;
			clamp_low_q  <= 1'b0;
			clamp_high_q <= 1'b0;
			fault_out_q  <= 1'b0;
		end else begin
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						pos_q     <= position;
						tgt_q     <= target_position;
						cmd_q     <= direct_command;
						neutral_q <= 1'b0;
						trip_q    <= 1'b0;
						lo_q      <= 1'b0;
						hi_q      <= 1'b0;
						state_q   <= S_VEL;
					end
				end
				S_VEL: begin
					vel_q  <= vel_n;
					t_q    <= t_n;
					prev_q <= pos_q;
					if (fault_q) begin
						neutral_q <= 1'b1;
						state_q   <= S_DRV;
					end else if (mode_q >= MODE_VELOCITY) begin
						mul_a_q  <= vel_n;
						acc_hi_q <= '0;
						acc_lo_q <= speed_gain_q;
						cnt_q    <= '0;
						ret_q    <= S_ERR;
						state_q  <= S_MUL;
					end else if (mode_q == MODE_TORQUE) begin
						mul_a_q  <= vel_n;
						acc_hi_q <= '0;
						acc_lo_q <= emf_gain_q;
						cnt_q    <= '0;
						ret_q    <= S_EMF;
						state_q  <= S_MUL;
					end else begin
						state_q <= S_DRV;
					end
				end
				S_MUL: begin
					acc_hi_q <= step_sum[17:1];
					acc_lo_q <= {step_sum[0], acc_lo_q[15:1]};
					cnt_q    <= cnt_q + 4'd1;
					if (cnt_q == 4'd15) begin
						state_q <= ret_q;
					end
				end
				S_ERR: begin
					err_q    <= err_n;
					mul_a_q  <= err_n;
					acc_hi_q <= '0;
					acc_lo_q <= prop_gain_q;
					ret_q    <= S_Z1;
					state_q  <= S_MUL;
				end
				S_Z1: begin
					p2_q     <= mq;
					mul_a_q  <= integ_q;
					acc_hi_q <= '0;
					acc_lo_q <= integ_gain_q;
					ret_q    <= S_Z;
					state_q  <= S_MUL;
				end
				S_Z: begin
					lo_q <= lo_n;
					hi_q <= hi_n;
					t_q  <= z_n;
					if (trip_n) begin
						fault_q   <= 1'b1;
						integ_q   <= '0;
						timer_q   <= '0;
						trip_q    <= 1'b1;
						neutral_q <= 1'b1;
						state_q   <= S_DRV;
					end else begin
						integ_q  <= integ_n;
						timer_q  <= timer_n;
						mul_a_q  <= vel_q;
						acc_hi_q <= '0;
						acc_lo_q <= emf_gain_q;
						ret_q    <= S_EMF;
						state_q  <= S_MUL;
					end
				end
				S_EMF: begin
					t_q     <= t_emf;
					state_q <= S_DRV;
				end
				S_DRV: begin
					if (load_out) begin
						pwm_a_q      <= 8'(8'sd120 + v_n);
						pwm_b_q      <= 8'(8'sd120 - v_n);
						clamp_low_q  <= lo_q;
						clamp_high_q <= hi_q;
						fault_out_q  <= fault_q;
						state_q      <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// both clamp flags only when the torque limit is zero
	a_clamp_both: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && clamp_low && clamp_high |-> torque_limit_q == '0)
		else $error("both clamp flags with nonzero torque limit");

	// complementary duties always sum to full scale
	a_pwm_sum: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (9'(pwm_a) + 9'(pwm_b)) == 9'd240)
		else $error("pwm duties not complementary");

	// fault word drives neutral
	a_fault_neutral: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && fault |-> pwm_a == 8'd120 && pwm_b == 8'd120)
		else $error("fault word without neutral drive");

	// fault latch holds until reset
	a_fault_hold: assert property (@(posedge clk) disable iff (!arst_n)
		fault_q |=> fault_q)
		else $error("fault latch released");

	// a trip clears the loop state
	a_trip_clear: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_Z && trip_n |=> integ_q == '0 && timer_q == '0 && trip_q)
		else $error("trip did not clear integrator and timer");

endmodule
`default_nettype wire
